/* design/mwsm_pkg.sv */
// Package for the mecanum wheel speed mixer: register index codes,
// pipeline depth, field widths and the 16-bit saturation helper.
// No dependencies.
`default_nettype none

package mwsm_pkg;

    // Configuration register index codes
    typedef logic [2:0] t_cfg_addr;

    localparam t_cfg_addr CFG_FRONT_SPAN = 3'd0;
    localparam t_cfg_addr CFG_REAR_SPAN  = 3'd1;
    localparam t_cfg_addr CFG_CTR_DX     = 3'd2;
    localparam t_cfg_addr CFG_CTR_DY     = 3'd3;
    localparam t_cfg_addr CFG_INV_MAX_W  = 3'd4;
    localparam t_cfg_addr CFG_SPEED_RPM  = 3'd5;

    // Register reset values
    localparam logic [15:0] RST_FRONT_SPAN = 16'd8192;
    localparam logic [15:0] RST_REAR_SPAN  = 16'd8192;
    localparam logic [15:0] RST_INV_MAX_W  = 16'd256;
    localparam logic [15:0] RST_SPEED_RPM  = 16'd16384;

    localparam int NUM_STAGES = 6;
    localparam int NUM_WHEELS = 4;
    localparam int FIELD_W    = 16;
    localparam int SAT_IN_W   = 48;

    typedef logic signed [FIELD_W-1:0] t_rpm;

    // Clamp a wide signed value into signed 16 bits
    function automatic t_rpm sat16(input logic signed [SAT_IN_W-1:0] v);
        t_rpm res;
        if (v > 48'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -48'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* design/mecanum_wheel_speed_mixer_core.sv */
// Top level of the mecanum wheel speed mixer: six-stage multiply-add
// pipeline from a chassis command to six saturated wheel speeds.
// Depends on mwsm_pkg.
`default_nettype none

// Usage
// -----
// Input stream (s_axis): one chassis command per transfer. tdata carries
// vel_x, vel_y, rot_rate, extend_vel (signed Q7.8); tuser carries
// climb_mode. Output stream (m_axis): one transfer per command with six
// signed 16-bit wheel speeds in rpm, in command order.
// Configuration: i_cfg_we writes i_cfg_wdata into the register chosen by
// i_cfg_addr (spans, center offsets, 1/max rotation, rpm factor); indexes
// above the last register are dropped. Write only while no command is in
// flight; stages 0, 1, 2 and 4 read the registers directly.
// Pipeline: an input transfer passes through six register stages to the
// output: rotation scale, offset products, levers, lever times rotation,
// rpm partial products, recombine and saturate.
// Throughput: one command per cycle while i_m_axis_tready is high. Every
// stage has its own valid bit; a stage advances when it is empty or the
// stage after it advances, so bubbles close up and a stall on
// i_m_axis_tready holds the whole chain only once it is full. Nothing is
// dropped or repeated on a stall.
// Reset (synchronous, i_rst_n low): clear all valid bits and load the
// register reset values. The block is ready as soon as reset is released.
module mecanum_wheel_speed_mixer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    // command stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata: [15:0] vel_x, [31:16] vel_y, [47:32] rot_rate, [63:48] extend_vel
    input  wire logic [63:0] i_s_axis_tdata,
    // tuser: [0] climb_mode
    input  wire logic        i_s_axis_tuser,
    // wheel speed stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tdata: [15:0] front-left wheel rpm, [31:16] front-right wheel rpm,
    // [47:32] rear-left wheel rpm, [63:48] rear-right wheel rpm,
    // [79:64] extend_left_rpm, [95:80] extend_right_rpm
    output logic [95:0]      o_m_axis_tdata
);

    localparam int NSTG = mwsm_pkg::NUM_STAGES;
    localparam int NWHL = mwsm_pkg::NUM_WHEELS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        [15:0] r_front_span;
    logic        [15:0] r_rear_span;
    logic signed [15:0] r_ctr_dx;
    logic signed [15:0] r_ctr_dy;
    logic        [15:0] r_inv_max_w;
    logic        [15:0] r_speed_rpm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_span <= mwsm_pkg::RST_FRONT_SPAN;
            r_rear_span  <= mwsm_pkg::RST_REAR_SPAN;
            r_ctr_dx     <= '0;
            r_ctr_dy     <= '0;
            r_inv_max_w  <= mwsm_pkg::RST_INV_MAX_W;
            r_speed_rpm  <= mwsm_pkg::RST_SPEED_RPM;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mwsm_pkg::CFG_FRONT_SPAN: r_front_span <= i_cfg_wdata;
                mwsm_pkg::CFG_REAR_SPAN:  r_rear_span  <= i_cfg_wdata;
                mwsm_pkg::CFG_CTR_DX:     r_ctr_dx     <= i_cfg_wdata;
                mwsm_pkg::CFG_CTR_DY:     r_ctr_dy     <= i_cfg_wdata;
                mwsm_pkg::CFG_INV_MAX_W:  r_inv_max_w  <= i_cfg_wdata;
                mwsm_pkg::CFG_SPEED_RPM:  r_speed_rpm  <= i_cfg_wdata;
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // rpm factor as a non-negative signed operand
    logic signed [16:0] w_speed_s;
    assign w_speed_s = $signed({1'b0, r_speed_rpm});

    // ------------------------------------------------------------------
    // Valid chain: a stage advances when empty or when its successor does
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] w_adv;

    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_comb begin
        n_vld[0] = w_adv[0] ? i_s_axis_tvalid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = w_adv[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_s_axis_tready = w_adv[0];
    assign o_m_axis_tvalid = r_vld[NSTG-1];

    // ------------------------------------------------------------------
    // Stage 0: |rot_rate| * inv_max_rotation, linear sums, extension sum
    // ------------------------------------------------------------------
    logic signed [15:0] w_vel_x, w_vel_y, w_rot, w_ext;
    logic        [15:0] w_abs_rot;

    assign w_vel_x   = i_s_axis_tdata[15:0];
    assign w_vel_y   = i_s_axis_tdata[31:16];
    assign w_rot     = i_s_axis_tdata[47:32];
    assign w_ext     = i_s_axis_tdata[63:48];
    // two's complement negate; the most negative value maps to 32768
    assign w_abs_rot = w_rot[15] ? (~w_rot + 16'd1) : w_rot;

    logic        [31:0] r0_scale;     // Q.16
    logic signed [15:0] r0_rot;
    logic signed [16:0] r0_sum_xy;    // vel_x + vel_y
    logic signed [16:0] r0_dif_xy;    // vel_x - vel_y
    logic signed [16:0] r0_ext;       // extension velocity, Q.8

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r0_scale  <= 32'(w_abs_rot) * 32'(r_inv_max_w);
            r0_rot    <= w_rot;
            r0_sum_xy <= 17'(w_vel_x) + 17'(w_vel_y);
            r0_dif_xy <= 17'(w_vel_x) - 17'(w_vel_y);
            r0_ext    <= i_s_axis_tuser ? 17'(w_ext) : (17'(w_vel_y) + 17'(w_ext));
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: offset products (Q.28) and extension product (Q.12)
    // ------------------------------------------------------------------
    logic signed [48:0] r1_prod_x;
    logic signed [48:0] r1_prod_y;
    logic signed [33:0] r1_ext_prod;
    logic signed [15:0] r1_rot;
    logic signed [16:0] r1_sum_xy;
    logic signed [16:0] r1_dif_xy;

    logic signed [32:0] w_scale_s;
    assign w_scale_s = $signed({1'b0, r0_scale});

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r1_prod_x   <= 49'(r_ctr_dx) * 49'(w_scale_s);
            r1_prod_y   <= 49'(r_ctr_dy) * 49'(w_scale_s);
            r1_ext_prod <= 34'(r0_ext) * 34'(w_speed_s);
            r1_rot      <= r0_rot;
            r1_sum_xy   <= r0_sum_xy;
            r1_dif_xy   <= r0_dif_xy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: round offsets to Q.12, build the four levers; finish the
    // extension wheels (round, negate, clamp)
    // ------------------------------------------------------------------
    logic signed [48:0] w_rx_full, w_ry_full;
    logic signed [32:0] w_tx, w_ty;
    logic signed [34:0] w_fs, w_rs;
    logic signed [34:0] w_ext_l_full, w_ext_r_full;

    always_comb begin
        w_rx_full    = (r1_prod_x + 49'sd32768) >>> 16;
        w_ry_full    = (r1_prod_y + 49'sd32768) >>> 16;
        w_tx         = 33'(w_rx_full);
        w_ty         = 33'(w_ry_full);
        w_fs         = $signed({19'd0, r_front_span});
        w_rs         = $signed({19'd0, r_rear_span});
        w_ext_l_full = (35'(r1_ext_prod) + 35'sd2048) >>> 12;
        w_ext_r_full = (35'sd2048 - 35'(r1_ext_prod)) >>> 12;
    end

    logic signed [34:0] r2_lever [NWHL];   // Q.12
    logic signed [15:0] r2_ext_l;
    logic signed [15:0] r2_ext_r;
    logic signed [15:0] r2_rot;
    logic signed [16:0] r2_sum_xy;
    logic signed [16:0] r2_dif_xy;

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r2_lever[0] <= w_fs - 35'(w_ty) + 35'(w_tx);   // left front
            r2_lever[1] <= w_fs - 35'(w_ty) - 35'(w_tx);   // right front
            r2_lever[2] <= w_rs + 35'(w_ty) + 35'(w_tx);   // left rear
            r2_lever[3] <= w_rs + 35'(w_ty) - 35'(w_tx);   // right rear
            r2_ext_l    <= mwsm_pkg::sat16(48'(w_ext_l_full));
            r2_ext_r    <= mwsm_pkg::sat16(48'(w_ext_r_full));
            r2_rot      <= r1_rot;
            r2_sum_xy   <= r1_sum_xy;
            r2_dif_xy   <= r1_dif_xy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: wheel sum in Q.20 = lin * 4096 - lever * rot_rate
    // ------------------------------------------------------------------
    logic signed [17:0] w_lin [NWHL];

    always_comb begin
        w_lin[0] = 18'(r2_sum_xy);        // +vx +vy
        w_lin[1] = 18'(r2_dif_xy);        // +vx -vy
        w_lin[2] = -18'(r2_dif_xy);       // -vx +vy
        w_lin[3] = -18'(r2_sum_xy);       // -vx -vy
    end

    logic signed [51:0] r3_sum [NWHL];
    logic signed [15:0] r3_ext_l;
    logic signed [15:0] r3_ext_r;

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            for (int k = 0; k < NWHL; k++) begin
                r3_sum[k] <= (52'(w_lin[k]) <<< 12) - 52'(r2_lever[k] * 51'(r2_rot));
            end
            r3_ext_l <= r2_ext_l;
            r3_ext_r <= r2_ext_r;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sum * speed_to_rpm as two partial products (split at bit 26)
    // ------------------------------------------------------------------
    logic signed [42:0] r4_hi [NWHL];
    logic        [41:0] r4_lo [NWHL];
    logic signed [15:0] r4_ext_l;
    logic signed [15:0] r4_ext_r;

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            for (int k = 0; k < NWHL; k++) begin
                r4_hi[k] <= 43'($signed(r3_sum[k][51:26])) * 43'(w_speed_s);
                r4_lo[k] <= 42'(r3_sum[k][25:0]) * 42'(r_speed_rpm);
            end
            r4_ext_l <= r3_ext_l;
            r4_ext_r <= r3_ext_r;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: recombine, round at bit 24, clamp; output register
    // ------------------------------------------------------------------
    logic        [42:0] w_lo_rnd [NWHL];
    logic signed [44:0] w_rpm_full [NWHL];

    always_comb begin
        for (int k = 0; k < NWHL; k++) begin
            // the high part lands at bit 26, already a multiple of 2^24
            w_lo_rnd[k]   = {1'b0, r4_lo[k]} + (43'd1 << 23);
            w_rpm_full[k] = $signed({r4_hi[k], 2'b00}) + $signed({26'd0, w_lo_rnd[k][42:24]});
        end
    end

    logic signed [15:0] r5_rpm [NWHL];
    logic signed [15:0] r5_ext_l;
    logic signed [15:0] r5_ext_r;

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            for (int k = 0; k < NWHL; k++) begin
                r5_rpm[k] <= mwsm_pkg::sat16(48'(w_rpm_full[k]));
            end
            r5_ext_l <= r4_ext_l;
            r5_ext_r <= r4_ext_r;
        end
    end

    assign o_m_axis_tdata = {r5_ext_r, r5_ext_l, r5_rpm[3], r5_rpm[2], r5_rpm[1], r5_rpm[0]};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_fills_stage0 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted command did not enter the first stage");

    a_full_stall_blocks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("full pipeline accepted a command during an output stall");

    a_held_stage_keeps_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !w_adv[2]) |=> r_vld[2])
        else $error("stalled mid stage lost its item");

    a_reset_clears_valid : assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("reset left a stage valid");

endmodule

`default_nettype wire

/* verif/mwsm_flow_checker.sv */
// Checker for the mecanum wheel speed mixer: watches the config port and both
// streams, predicts six wheel speeds per command and compares them in order.
// Depends on mwsm_pkg.
`default_nettype none

module mwsm_flow_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    // tdata: [15:0] vel_x, [31:16] vel_y, [47:32] rot_rate, [63:48] extend_vel
    input  wire logic [63:0] i_s_tdata,
    // tuser: [0] climb_mode
    input  wire logic        i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    // tdata: [15:0] front-left, [31:16] front-right, [47:32] rear-left,
    // [63:48] rear-right, [79:64] extend_left, [95:80] extend_right
    input  wire logic [95:0] i_m_tdata,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // first member sits in the top bits, so the front-left wheel lands in [15:0]
    typedef struct packed {
        mwsm_pkg::t_rpm extend_right;
        mwsm_pkg::t_rpm extend_left;
        mwsm_pkg::t_rpm rear_r;
        mwsm_pkg::t_rpm rear_l;
        mwsm_pkg::t_rpm front_r;
        mwsm_pkg::t_rpm front_l;
    } t_wheel_speeds;

    longint front_span;
    longint rear_span;
    longint ctr_dx;
    longint ctr_dy;
    longint inv_max_w;
    longint rpm_factor;

    t_wheel_speeds expected_speeds[$];
    int            fail_count = 0;

    // round half up, then drop s fraction bits
    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic mwsm_pkg::t_rpm clamp16(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return mwsm_pkg::t_rpm'(v);
    endfunction

    // (linear term in Q.8 shifted to Q.20) minus lever (Q.12) times rotation (Q.8)
    function automatic mwsm_pkg::t_rpm wheel_rpm(longint lin, longint lever, longint w);
        return clamp16(round_shift((lin * 4096 - lever * w) * rpm_factor, 24));
    endfunction

    function automatic t_wheel_speeds mix_wheels(logic [63:0] cmd, logic climb);
        longint        vx, vy, w, ext, aw, scale, tx, ty, e, p;
        t_wheel_speeds r;
        vx  = longint'($signed(cmd[15:0]));
        vy  = longint'($signed(cmd[31:16]));
        w   = longint'($signed(cmd[47:32]));
        ext = longint'($signed(cmd[63:48]));
        aw  = (w < 0) ? -w : w;
        // rotation center shift grows with |w| / max_w
        scale = aw * inv_max_w;
        tx    = round_shift(ctr_dx * scale, 16);
        ty    = round_shift(ctr_dy * scale, 16);
        r.front_l = wheel_rpm(vx + vy,  front_span - ty + tx, w);
        r.front_r = wheel_rpm(vx - vy,  front_span - ty - tx, w);
        r.rear_l  = wheel_rpm(-vx + vy, rear_span + ty + tx,  w);
        r.rear_r  = wheel_rpm(-vx - vy, rear_span + ty - tx,  w);
        // climbing drops the sideways part on the extension wheels
        e = (climb ? 64'sd0 : vy) + ext;
        p = e * rpm_factor;
        r.extend_left  = clamp16(round_shift(p, 12));
        r.extend_right = clamp16(round_shift(-p, 12));
        return r;
    endfunction

    task automatic check_speed(string wheel, mwsm_pkg::t_rpm want, mwsm_pkg::t_rpm got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, wheel, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_wheel_speeds want;
        t_wheel_speeds got;
        if (!i_rst_n) begin
            front_span = longint'(mwsm_pkg::RST_FRONT_SPAN);
            rear_span  = longint'(mwsm_pkg::RST_REAR_SPAN);
            ctr_dx     = 0;
            ctr_dy     = 0;
            inv_max_w  = longint'(mwsm_pkg::RST_INV_MAX_W);
            rpm_factor = longint'(mwsm_pkg::RST_SPEED_RPM);
            expected_speeds.delete();
        end else begin
            if (i_cfg_we) begin
                case (mwsm_pkg::t_cfg_addr'(i_cfg_addr))
                    mwsm_pkg::CFG_FRONT_SPAN: front_span = longint'(i_cfg_wdata);
                    mwsm_pkg::CFG_REAR_SPAN:  rear_span  = longint'(i_cfg_wdata);
                    mwsm_pkg::CFG_CTR_DX:     ctr_dx     = longint'($signed(i_cfg_wdata));
                    mwsm_pkg::CFG_CTR_DY:     ctr_dy     = longint'($signed(i_cfg_wdata));
                    mwsm_pkg::CFG_INV_MAX_W:  inv_max_w  = longint'(i_cfg_wdata);
                    mwsm_pkg::CFG_SPEED_RPM:  rpm_factor = longint'(i_cfg_wdata);
                    default: ;  // drop writes to spare indexes
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_speeds.push_back(mix_wheels(i_s_tdata, i_s_tuser));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (expected_speeds.size() == 0) begin
                    $display("%0t ns: unexpected transfer, expected none, actual %h",
                             $time, i_m_tdata);
                    fail_count++;
                end else begin
                    want = expected_speeds.pop_front();
                    check_speed("front-left rpm",   want.front_l,      got.front_l);
                    check_speed("front-right rpm",  want.front_r,      got.front_r);
                    check_speed("rear-left rpm",    want.rear_l,       got.rear_l);
                    check_speed("rear-right rpm",   want.rear_r,       got.rear_r);
                    check_speed("extend_left_rpm",  want.extend_left,  got.extend_left);
                    check_speed("extend_right_rpm", want.extend_right, got.extend_right);
                end
            end
        end
        o_pending    <= expected_speeds.size();
        o_fail_count <= fail_count;
    end

endmodule

`default_nettype wire

/* verif/tb.sv */
// Top of the mecanum wheel speed mixer testbench: clock, reset, command
// stimulus, output back-pressure and the verdict.
// Depends on mwsm_pkg, mecanum_wheel_speed_mixer_core and mwsm_flow_checker.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 2;
    localparam int RST_CYCLES      = 6;
    localparam int IDLE_PCT        = 24;    // percent of cycles the sink idles
    localparam int SRC_GAP_PCT     = 16;    // percent chance of an idle gap before a command, ~24% idle
    localparam int STALL_AT        = 700;   // commands sent before the long sink stall
    localparam int STALL_LEN       = 100;
    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transfer on either side

    // indexes past the last register; the block must drop these writes
    localparam mwsm_pkg::t_cfg_addr CFG_SPARE_LO = 3'd6;
    localparam mwsm_pkg::t_cfg_addr CFG_SPARE_HI = 3'd7;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_we        = 1'b0;
    mwsm_pkg::t_cfg_addr i_cfg_addr      = mwsm_pkg::CFG_FRONT_SPAN;
    logic [15:0]         i_cfg_wdata     = '0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [63:0]         i_s_axis_tdata  = '0;
    logic                i_s_axis_tuser  = 1'b0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [95:0]         o_m_axis_tdata;

    int   fail_count;
    int   pending;
    int   sent_count   = 0;
    int   stuck_cycles = 0;
    int   stall_left   = 0;
    logic stall_done   = 1'b0;
    logic no_idle      = 1'b0;  // both sides run flat out while set
    logic s_taken      = 1'b0;

    always #(CLK_HALF) i_clk = ~i_clk;

    mecanum_wheel_speed_mixer_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    mwsm_flow_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tuser    (i_s_axis_tuser),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Capture input transfers and count dead cycles at the edge; the
    // stimulus reads the captured transfer flag on the following falling edge.
    always @(posedge i_clk) begin
        s_taken <= i_s_axis_tvalid && o_s_axis_tready;
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Sink: random back-pressure, plus one long hold-off once enough
    // commands are in so the pipeline fills and stalls the input side.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left      <= stall_left - 1;
        end else if (!stall_done && sent_count >= STALL_AT) begin
            i_m_axis_tready <= 1'b0;
            stall_left      <= STALL_LEN - 1;
            stall_done      <= 1'b1;
        end else begin
            i_m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run if transfers stop.
    initial begin
        wait (stuck_cycles >= WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Present one command and hold it until the transfer. Return on the
    // falling edge after it, with tvalid still high: the caller either
    // sends the next command or drops tvalid in this same step.
    task automatic send_cmd(logic [15:0] vx, logic [15:0] vy, logic [15:0] w,
                            logic [15:0] ext, logic climb);
        if (!no_idle && $urandom_range(99) < SRC_GAP_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {ext, w, vy, vx};
        i_s_axis_tuser  <= climb;
        do @(negedge i_clk); while (!s_taken);
        sent_count++;
    endtask

    // Mostly full-range values, a good share of small ones so the wheels
    // are not always saturated, and some hard extremes.
    function automatic logic [15:0] pick_field();
        logic [15:0] corners[5];
        corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
        case ($urandom_range(9))
            0:       return corners[$urandom_range(4)];
            1, 2, 3: return 16'($urandom_range(2048)) - 16'd1024;
            default: return 16'($urandom);
        endcase
    endfunction

    // Drop tvalid, wait for every expected result, then let the pipeline
    // settle past its latency.
    task automatic drain_and_settle();
        i_s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (mwsm_pkg::NUM_STAGES + 2) @(negedge i_clk);
    endtask

    // Drain, then write all six registers, then junk to both spare indexes.
    task automatic apply_settings(logic [15:0] front, logic [15:0] rear,
                                  logic [15:0] offx, logic [15:0] offy,
                                  logic [15:0] inv, logic [15:0] rpm);
        mwsm_pkg::t_cfg_addr idx[8];
        logic [15:0]         val[8];
        idx = '{mwsm_pkg::CFG_FRONT_SPAN, mwsm_pkg::CFG_REAR_SPAN,
                mwsm_pkg::CFG_CTR_DX, mwsm_pkg::CFG_CTR_DY,
                mwsm_pkg::CFG_INV_MAX_W, mwsm_pkg::CFG_SPEED_RPM,
                CFG_SPARE_LO, CFG_SPARE_HI};
        val = '{front, rear, offx, offy, inv, rpm, 16'($urandom), 16'($urandom)};
        drain_and_settle();
        foreach (idx[k]) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= idx[k];
            i_cfg_wdata <= val[k];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed commands at the reset settings: zero, each field at both
        // ends, climb on and off, and sums far past the 16-bit rpm range.
        send_cmd(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_cmd(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_cmd(16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_cmd(16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0);
        send_cmd(16'h0000, 16'h8000, 16'h0000, 16'h0000, 1'b1);
        send_cmd(16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 1'b0);
        send_cmd(16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b0);
        send_cmd(16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 1'b0);
        send_cmd(16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b1);
        send_cmd(16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF, 1'b0);
        send_cmd(16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF, 1'b1);
        send_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        send_cmd(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
        send_cmd(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b0);
        send_cmd(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_cmd(16'h0100, 16'hFF80, 16'h0040, 16'h0080, 1'b0);
        send_cmd(16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                // everything at the top end
                0: apply_settings(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF,
                                  16'hFFFF, 16'hFFFF);
                // zero spans, most negative offsets
                1: apply_settings(16'h0000, 16'h0000, 16'h8000, 16'h8000,
                                  16'hFFFF, 16'h4000);
                // zero reciprocal: offsets must drop out
                2: apply_settings(16'h2000, 16'h3000, 16'h7FFF, 16'h8000,
                                  16'h0000, 16'h4000);
                // zero rpm factor, lopsided spans
                3: apply_settings(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF,
                                  16'h0100, 16'h0000);
                default: begin
                    if ($urandom_range(3) == 0) begin
                        apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                                       16'($urandom), 16'($urandom), 16'($urandom));
                    end else begin
                        // realistic chassis: spans up to 4 m, offsets within 1 m
                        apply_settings(16'($urandom_range(16384)),
                                       16'($urandom_range(16384)),
                                       16'($urandom_range(8192)) - 16'd4096,
                                       16'($urandom_range(8192)) - 16'd4096,
                                       16'($urandom_range(1024)),
                                       16'($urandom_range(32768)));
                    end
                end
            endcase
            no_idle = (ph == 5);
            repeat (ITEMS_PER_PHASE) begin
                send_cmd(pick_field(), pick_field(), pick_field(), pick_field(),
                         1'($urandom));
            end
        end
        no_idle = 1'b0;

        drain_and_settle();
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
design/mwsm_pkg.sv
design/mecanum_wheel_speed_mixer_core.sv
verif/mwsm_flow_checker.sv
verif/tb.sv
